>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> sv/sitd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_pkg
// types and constants of the signed integer to decimal text converter
// ----------------------------------------------------------------------------
package sitd_pkg;

  // widths
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BitCntW  = $clog2(ValueW);
  localparam int unsigned DigCntW  = $clog2(NumDigits + 1);

  // characters
  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  // add-3 threshold of a bcd digit
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // control of the digit cell row
  typedef struct packed {
    logic clear;  // zero the digit
    logic shift;  // add-3 correct, then shift one bit in
    logic roll;   // take the digit of the lower neighbour
  } cell_ctrl_t;

endpackage

>>> sv/sitd_bcd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_bcd_cell
// one bcd digit of the double-dabble row, passes a bit and a digit upward
// ----------------------------------------------------------------------------
module sitd_bcd_cell (
  input  logic                           clk_i,
  input  sitd_pkg::cell_ctrl_t           ctrl_i,
  input  logic                           bit_i,    // carry from lower cell
  input  logic [sitd_pkg::DigitW-1:0]    digit_i,  // digit of lower cell
  output logic                           bit_o,    // carry to upper cell
  output logic [sitd_pkg::DigitW-1:0]    digit_o
);

  logic [sitd_pkg::DigitW-1:0] digit_q;
  logic [sitd_pkg::DigitW-1:0] digit_d;
  logic [sitd_pkg::DigitW-1:0] fixed;

  // add-3 correction ahead of the shift
  always_comb begin
    if (digit_q >= sitd_pkg::DabbleLimit) begin
      fixed = digit_q + sitd_pkg::DabbleAdd;
    end else begin
      fixed = digit_q;
    end
  end

  assign bit_o   = fixed[sitd_pkg::DigitW-1];
  assign digit_o = digit_q;

  // next digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {fixed[sitd_pkg::DigitW-2:0], bit_i};
    end else if (ctrl_i.roll) begin
      digit_d = digit_i;
    end
  end

  // digit register
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

>>> sv/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer to its decimal ascii text
// ----------------------------------------------------------------------------
// One input item is a two's complement integer; the block returns its decimal
// text most significant character first, one output item per character, with
// a leading '-' for negative values and tlast on the final digit (zero gives
// "0", the most negative value gives "-2147483648"). One item is converted at
// a time: after acceptance the magnitude is shifted bit by bit into a row of
// ten bcd digit cells, then the row is rolled up one digit per cycle, leading
// zeros being skipped; a significant digit waits while the output side stalls.
// The sign of a negative value goes out ahead of the digits and also waits
// on the output side. The last character may still wait in the output
// register while the next item converts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [sitd_pkg::ValueW-1:0]   s_axis_tdata_i,   // [31:0] value
  // output items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sitd_pkg::CharW-1:0]    m_axis_tdata_o,   // [7:0] text_char
  output logic                          m_axis_tlast_o    // last
);

  localparam int unsigned NumDigits = sitd_pkg::NumDigits;
  localparam int unsigned DigitW    = sitd_pkg::DigitW;

  sitd_pkg::state_e                state_q, state_d;
  logic [sitd_pkg::ValueW-1:0]     mag_q, mag_d;
  logic [sitd_pkg::BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [sitd_pkg::DigCntW-1:0]    dig_left_q, dig_left_d;
  logic                            sign_pend_q, sign_pend_d;
  logic                            seen_q, seen_d;
  logic                            out_valid_q, out_valid_d;
  logic [sitd_pkg::CharW-1:0]      out_char_q, out_char_d;
  logic                            out_last_q, out_last_d;

  sitd_pkg::cell_ctrl_t            cell_ctrl;
  logic [NumDigits:0]              carry;
  logic [DigitW-1:0]               digit [NumDigits+1];
  logic [DigitW-1:0]               top_digit;
  logic                            in_fire;
  logic                            can_load;
  logic                            negative;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load  = !out_valid_q || m_axis_tready_i;
  assign negative  = s_axis_tdata_i[sitd_pkg::ValueW-1];
  assign top_digit = digit[NumDigits];

  // row of bcd cells, lowest digit first
  assign carry[0] = mag_q[sitd_pkg::ValueW-1];
  assign digit[0] = '0;

  for (genvar gi = 0; gi < NumDigits; gi++) begin : g_cell
    sitd_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (carry[gi]),
      .digit_i (digit[gi]),
      .bit_o   (carry[gi+1]),
      .digit_o (digit[gi+1])
    );
  end

  // sequencer: accept, shift in, roll out
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bit_cnt_d   = bit_cnt_q;
    dig_left_d  = dig_left_q;
    sign_pend_d = sign_pend_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    cell_ctrl   = '0;

    unique case (state_q)
      sitd_pkg::ST_IDLE: begin
        if (in_fire) begin
          cell_ctrl.clear = 1'b1;
          mag_d       = negative ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;
          sign_pend_d = negative;
          bit_cnt_d   = '0;
          state_d     = sitd_pkg::ST_CONV;
        end
      end
      sitd_pkg::ST_CONV: begin
        cell_ctrl.shift = 1'b1;
        mag_d     = {mag_q[sitd_pkg::ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == sitd_pkg::BitCntW'(sitd_pkg::ValueW - 1)) begin
          dig_left_d = sitd_pkg::DigCntW'(NumDigits);
          seen_d     = 1'b0;
          state_d    = sitd_pkg::ST_EMIT;
        end
      end
      sitd_pkg::ST_EMIT: begin
        if (sign_pend_q) begin
          // sign goes out ahead of the digits
          if (can_load) begin
            out_valid_d = 1'b1;
            out_char_d  = sitd_pkg::CharMinus;
            out_last_d  = 1'b0;
            sign_pend_d = 1'b0;
          end
        end else if (seen_q || (top_digit != '0) || (dig_left_q == 1)) begin
          // significant digit
          if (can_load) begin
            out_valid_d    = 1'b1;
            out_char_d     = sitd_pkg::CharZero + sitd_pkg::CharW'(top_digit);
            out_last_d     = (dig_left_q == 1);
            cell_ctrl.roll = 1'b1;
            seen_d         = 1'b1;
            dig_left_d     = dig_left_q - 1'b1;
            if (dig_left_q == 1) begin
              state_d = sitd_pkg::ST_IDLE;
            end
          end
        end else begin
          // leading zero, dropped
          cell_ctrl.roll = 1'b1;
          dig_left_d     = dig_left_q - 1'b1;
        end
      end
      default: begin
        state_d = sitd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    bit_cnt_q   <= bit_cnt_d;
    dig_left_q  <= dig_left_d;
    sign_pend_q <= sign_pend_d;
    seen_q      <= seen_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == sitd_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  `ASSERT_PROP(a_accept_starts_conv, in_fire |=> (state_q == sitd_pkg::ST_CONV && bit_cnt_q == '0), "accepted item did not start conversion")
  `ASSERT_NEVER(a_emit_no_digits, (state_q == sitd_pkg::ST_EMIT) && (dig_left_q == '0), "emitting with no digits left")
  `ASSERT_NEVER(a_bad_bcd, (state_q == sitd_pkg::ST_EMIT) && (top_digit > 4'd9), "bcd digit out of range")
  `ASSERT_NEVER(a_sign_is_last, m_axis_tvalid_o && m_axis_tlast_o && (m_axis_tdata_o == sitd_pkg::CharMinus), "sign marked as last character")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the signed integer to decimal ascii converter
// ----------------------------------------------------------------------------
// Feeds 32-bit two's complement values into the converter and checks every
// text character and its tlast flag against table text or a digit-by-digit
// predictor. A table of corner values comes first: zero, unit values, powers
// of ten and their neighbours, both extremes and alternating bit patterns. A
// random part follows, mostly magnitudes of a chosen digit count with random
// sign, plus full-range patterns. Both stream sides idle at random, with one
// long calm window, and the sender drains the converter now and then.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NumRandom = 351;
  localparam int unsigned IdlePct   = 37;

  // one expected character of the decimal text
  typedef struct packed {
    logic [sitd_pkg::CharW-1:0] ch;
    logic                       last;
  } text_char_t;

  // directed row: value and, where obvious, its text (empty: use predictor)
  typedef struct {
    logic [sitd_pkg::ValueW-1:0] value;
    string                       text;
  } directed_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [sitd_pkg::ValueW-1:0]   s_axis_tdata_i = '0;    // [31:0] value
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [sitd_pkg::CharW-1:0]    m_axis_tdata_o;          // [7:0] text_char
  logic                          m_axis_tlast_o;          // last

  text_char_t pending_chars_q[$];
  int unsigned error_count    = 0;
  int unsigned values_sent    = 0;
  int unsigned negatives_sent = 0;
  int unsigned chars_checked  = 0;
  bit          calm = 1'b0;

  directed_row_t directed_rows [19] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'hFFFF_FFFF,  "-1"},
    '{32'd9,          "9"},
    '{32'hFFFF_FFF7,  "-9"},
    '{32'd10,         "10"},
    '{32'hFFFF_FFF6,  "-10"},
    '{32'd2147483647, "2147483647"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'd1000000000, "1000000000"},
    '{32'd999999999,  ""},
    '{32'hC465_3601,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'h5555_5555,  ""},
    '{32'd100,        ""},
    '{32'hFFFF_FF9C,  ""},
    '{32'd12345,      ""},
    '{32'd7,          ""}
  };

  signed_int_to_decimal_ascii_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // count and print one mismatch
  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // decimal text of a value, most significant character first
  function automatic void predict_decimal_text(input logic [sitd_pkg::ValueW-1:0] value);
    logic [sitd_pkg::ValueW-1:0] mag;
    logic [sitd_pkg::DigitW-1:0] digits [sitd_pkg::NumDigits];
    int                          n;
    bit                          negative;
    negative = value[sitd_pkg::ValueW-1];
    mag      = negative ? sitd_pkg::ValueW'(0) - value : value;
    n        = 0;
    do begin
      digits[n] = sitd_pkg::DigitW'(mag % 10);
      mag       = mag / 10;
      n++;
    end while (mag != 0 && n < sitd_pkg::NumDigits);
    if (negative) pending_chars_q.push_back('{ch: sitd_pkg::CharMinus, last: 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars_q.push_back('{ch: sitd_pkg::CharZero + sitd_pkg::CharW'(digits[k]),
                                  last: (k == 0)});
    end
  endfunction

  // offer one value, wait for acceptance, then record what it should produce
  task automatic offer_value(input logic [sitd_pkg::ValueW-1:0] value, input string text);
    if (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    values_sent++;
    if (value[sitd_pkg::ValueW-1]) negatives_sent++;
    if (text.len() == 0) begin
      predict_decimal_text(value);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars_q.push_back('{ch: sitd_pkg::CharW'(text[i]),
                                    last: (i == text.len() - 1)});
      end
    end
  endtask

  // hold the sender back until every expected character has come
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars_q.size() != 0);
  endtask

  // random value: mostly a chosen digit count, some full-range patterns
  function automatic logic [sitd_pkg::ValueW-1:0] random_value();
    longint lo, hi, mag;
    int     ndig;
    int     mode;
    bit     negative;
    mode     = $urandom_range(9);
    negative = $urandom_range(1);
    if (mode >= 7 && mode <= 8) return $urandom();
    ndig = $urandom_range(1, sitd_pkg::NumDigits);
    lo   = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647) hi = negative ? 64'd2147483648 : 64'd2147483647;
    if (mode == 9) begin
      // either end of the digit-count range
      mag = $urandom_range(1) ? lo : hi;
    end else begin
      mag = lo + longint'({$urandom(), $urandom()} % 64'(hi - lo + 1));
    end
    return negative ? sitd_pkg::ValueW'(-mag) : sitd_pkg::ValueW'(mag);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // output check against the oldest expected character
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      chars_checked++;
      if (pending_chars_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                  m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        want = pending_chars_q.pop_front();
        if (m_axis_tdata_o !== want.ch) begin
          report_mismatch($sformatf("char 0x%02h, want 0x%02h", m_axis_tdata_o, want.ch));
        end
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast_o, want.last));
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner values
    foreach (directed_rows[i]) offer_value(directed_rows[i].value, directed_rows[i].text);
    drain();

    // random values, with a calm window and occasional draining
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 120 && n < 190);
      if (n == 60 || n == 250) drain();
      offer_value(random_value(), "");
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // let the tail of the text come out
    while (pending_chars_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("converted %0d values (%0d negative) into %0d checked characters",
             values_sent, negatives_sent, chars_checked);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sitd_pkg.sv
sv/sitd_bcd_cell.sv
sv/signed_int_to_decimal_ascii_unit.sv
test/tb_top.sv
